>>> hw/rtl/ssnd_pkg.sv
// Package for the six-digit seven-segment number display.
// Holds mode and register codes, segment constants and the digit decoder.
// No dependencies.
`default_nettype none

package ssnd_pkg;

    localparam int DIGIT_COUNT = 6;
    localparam int BIN_WIDTH   = 20;
    localparam int CNT_WIDTH   = $clog2(BIN_WIDTH);
    localparam int BCD_WIDTH   = 4 * DIGIT_COUNT;
    localparam int POS_WIDTH   = $clog2(DIGIT_COUNT);
    localparam int CFG_WIDTH   = 20;

    // Item modes.
    localparam logic [1:0] MODE_PRINT = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_SCAN  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MAX_VALUE = 1'b0;
    localparam logic CFG_MIN_VALUE = 1'b1;

    localparam logic [19:0] MAX_VALUE_RESET = 20'd999999;
    localparam logic [17:0] MIN_VALUE_RESET = 18'h2_7961; // -99999

    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    // "-Error", position 0 is the rightmost digit.
    localparam logic [7:0] ERROR_PATTERN [DIGIT_COUNT] =
        '{8'h50, 8'h5c, 8'h50, 8'h50, 8'h79, 8'h40};

    typedef logic [7:0] t_segments;

    function automatic t_segments seg_of_digit(input logic [3:0] digit);
        t_segments seg;
        case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/seven_segment_number_display.sv
// A scan tick shows its digit on the output the cycle after its beat is accepted.
// A print in range loads the converter, runs 20 shift-and-correct steps and writes back;
// the input stalls meanwhile. Clear and out-of-range prints finish in the accepting cycle.
// Throughput: one beat per cycle for scan ticks and clears unless the output stalls.
// Reset (i_rst_n low, synchronous) blanks all digits, zeroes the scan position and
// restores the limit registers to 999999 and -99999.
`default_nettype none

module seven_segment_number_display (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_value,
    // Output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_segments,
    output logic [5:0]       o_digit_enable,
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);

    import ssnd_pkg::*;

    // The converter is a bit-serial double-dabble: the magnitude shifts out MSB first
    // into a six-digit BCD register, and every digit that has reached five gets three
    // added before each shift. Only six BCD digits are kept, so a seven-digit
    // magnitude keeps its six low digits, which is exactly what the display shows.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_WRITE
    } t_state;

    t_state                 r_state;
    logic [19:0]            r_max;
    logic [17:0]            r_min;
    t_segments              r_patterns [DIGIT_COUNT];
    logic [POS_WIDTH-1:0]   r_scan;
    logic                   r_out_valid;
    t_segments              r_out_seg;
    logic [DIGIT_COUNT-1:0] r_out_en;

    logic [BIN_WIDTH-1:0]   r_bin;
    logic [BCD_WIDTH-1:0]   r_bcd;
    logic [CNT_WIDTH-1:0]   r_cnt;
    logic                   r_neg;

    logic                   w_in_accept;
    logic                   w_out_free;
    logic signed [32:0]     w_val;
    logic signed [32:0]     w_hi;
    logic signed [32:0]     w_lo;
    logic                   w_out_of_range;
    logic [31:0]            w_abs;
    logic [BCD_WIDTH-1:0]   w_adj;
    logic [BCD_WIDTH-1:0]   n_bcd;
    logic [BIN_WIDTH-1:0]   n_bin;
    logic [POS_WIDTH-1:0]   w_pos;
    logic [POS_WIDTH-1:0]   n_scan;
    logic [POS_WIDTH-1:0]   w_places;
    t_segments              n_patterns [DIGIT_COUNT];

    // The output register can take a new beat when it is empty or being drained now.
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE) || !w_out_free;
    assign w_in_accept = i_valid && !o_stall;

    assign o_valid        = r_out_valid;
    assign o_segments     = r_out_seg;
    assign o_digit_enable = r_out_en;

    // Limit check in 33 bits so that both the unsigned upper limit and the signed
    // lower limit compare correctly against the full 32-bit signed value. Crossed
    // limits make every value fail one of the two tests.
    assign w_val          = {i_value[31], i_value};
    assign w_hi           = {13'b0, r_max};
    assign w_lo           = {{15{r_min[17]}}, r_min};
    assign w_out_of_range = (w_val > w_hi) || (w_val < w_lo);

    // A value that passed the check has a magnitude that fits in 20 bits.
    assign w_abs = i_value[31] ? (32'd0 - i_value) : i_value;

    // One double-dabble step: correct every digit, then shift the next bit in.
    always_comb begin
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? (r_bcd[4*k +: 4] + 4'd3)
                                                         : r_bcd[4*k +: 4];
        end
        n_bcd = {w_adj[BCD_WIDTH-2:0], r_bin[BIN_WIDTH-1]};
        n_bin = {r_bin[BIN_WIDTH-2:0], 1'b0};
    end

    // A negative number uses one to five digit places; the sign goes just above them.
    always_comb begin
        if (r_bcd[23:16] != 8'd0) begin
            w_places = 3'd5;
        end else if (r_bcd[15:12] != 4'd0) begin
            w_places = 3'd4;
        end else if (r_bcd[11:8] != 4'd0) begin
            w_places = 3'd3;
        end else if (r_bcd[7:4] != 4'd0) begin
            w_places = 3'd2;
        end else begin
            w_places = 3'd1;
        end
    end

    // Write-back patterns once the conversion is complete.
    always_comb begin
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (!r_neg || (POS_WIDTH'(k) < w_places)) begin
                n_patterns[k] = seg_of_digit(r_bcd[4*k +: 4]);
            end else if (POS_WIDTH'(k) == w_places) begin
                n_patterns[k] = SEG_MINUS;
            end else begin
                n_patterns[k] = SEG_BLANK;
            end
        end
    end

    // Scan position wraps after the leftmost digit.
    assign w_pos  = (r_scan >= POS_WIDTH'(DIGIT_COUNT)) ? '0 : r_scan;
    assign n_scan = (w_pos == POS_WIDTH'(DIGIT_COUNT - 1)) ? '0 : (w_pos + 1'b1);

    always_ff @(posedge i_clk) begin
        // Converter datapath; no reset needed, it is loaded at the start of a print.
        if (r_state == S_SHIFT) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
            r_cnt <= r_cnt + 1'b1;
        end

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= MAX_VALUE_RESET;
            r_min       <= MIN_VALUE_RESET;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < DIGIT_COUNT; k++) begin
                r_patterns[k] <= SEG_BLANK;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_VALUE: r_max <= i_cfg_data;
                    CFG_MIN_VALUE: r_min <= i_cfg_data[17:0];
                    default:       r_max <= r_max;
                endcase
            end

            // A waiting beat leaves once downstream stops stalling.
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        case (i_mode)
                            MODE_PRINT: begin
                                if (w_out_of_range) begin
                                    for (int k = 0; k < DIGIT_COUNT; k++) begin
                                        r_patterns[k] <= ERROR_PATTERN[k];
                                    end
                                end else begin
                                    r_bin   <= w_abs[BIN_WIDTH-1:0];
                                    r_bcd   <= '0;
                                    r_cnt   <= '0;
                                    r_neg   <= i_value[31];
                                    r_state <= S_SHIFT;
                                end
                            end
                            MODE_CLEAR: begin
                                for (int k = 0; k < DIGIT_COUNT; k++) begin
                                    r_patterns[k] <= SEG_BLANK;
                                end
                            end
                            MODE_SCAN: begin
                                r_out_valid <= 1'b1;
                                r_out_seg   <= r_patterns[w_pos];
                                r_out_en    <= DIGIT_COUNT'(1 << (DIGIT_COUNT - 1)) >> w_pos;
                                r_scan      <= n_scan;
                            end
                            default: begin
                                // The unused mode code is accepted and ignored.
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    if (r_cnt == CNT_WIDTH'(BIN_WIDTH - 1)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    for (int k = 0; k < DIGIT_COUNT; k++) begin
                        r_patterns[k] <= n_patterns[k];
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ssnd_checker.sv
// Port-level checker for the seven-segment number display, bound to the top level.
// Depends on ssnd_pkg for the mode codes.
`default_nettype none

module ssnd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [1:0]  i_mode,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_segments,
    input wire logic [5:0]  o_digit_enable
);

    import ssnd_pkg::*;

    // A stalled output beat stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_segments) && $stable(o_digit_enable)))
        else $error("stalled output beat changed");

    // Every beat drives exactly one digit line.
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(o_digit_enable))
        else $error("digit enable not one-hot");

    // An accepted scan tick yields a beat in the next cycle.
    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_mode == MODE_SCAN)) |=> o_valid)
        else $error("scan tick produced no beat");

    // Any other item, with no beat left waiting, yields no beat.
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_mode != MODE_SCAN) && !(o_valid && i_stall))
            |=> !o_valid)
        else $error("beat produced without a scan tick");

endmodule

bind seven_segment_number_display ssnd_checker u_ssnd_checker (.*);

`default_nettype wire
